// ===== rtl/lzw_pkg.sv =====
// Shared types and constants for the LZW compressor.
// Used by lzw_hash, lzw_dict, lzw_pack and the top level; no dependencies.
package lzw_pkg;

   // Literal codes 0..255 sit at their own slot and never match a lookup
   localparam int LIT_COUNT   = 256;
   localparam int CODE_W_INIT = 8;
   localparam int BYTE_W      = 8;
   // Hash is ((prefix << HASH_SHIFT) ^ byte) mod dictionary size
   localparam int HASH_SHIFT  = 5;
   // Remainder bits resolved per cycle by the non power-of-two hash reducer
   localparam int HASH_STEP   = 4;
   // Output bytes delivered per request at most
   localparam int MAX_RESULTS = 4;
   localparam int COUNT_W     = 24;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFF_FFFF;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_LOOK,
      CTL_EMIT_MISS,
      CTL_EMIT_EOS
   } ctl_state_type;

   typedef enum logic [1:0] {
      DICT_CLEAR,
      DICT_IDLE,
      DICT_HASH,
      DICT_PROBE
   } dict_state_type;

   // Control from the sequencer to the dictionary
   typedef struct packed {
      logic lookup;
      logic clear;
      logic insert_en;
   } dict_req_type;

   // Status back from the dictionary
   typedef struct packed {
      logic ready;
      logic done;
      logic hit;
   } dict_sts_type;

   // Code packing command
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } pack_cmd_type;

endpackage

// ===== rtl/lzw_hash.sv =====
// Slot hash for the dictionary: key mod DICT_ENTRIES.
// Mask for a power-of-two size, restoring remainder otherwise. Depends on lzw_pkg.
module lzw_hash #(
   parameter int DICT_ENTRIES = 4096
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic [$clog2(DICT_ENTRIES)+lzw_pkg::HASH_SHIFT-1:0] key,
   output logic                                           done,
   output logic [$clog2(DICT_ENTRIES)-1:0]                hash
);
   import lzw_pkg::*;

   localparam int AW      = $clog2(DICT_ENTRIES);
   localparam int KEY_W   = AW + HASH_SHIFT;
   localparam bit IS_POW2 = (DICT_ENTRIES & (DICT_ENTRIES - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         logic          done_ff;
         logic [AW-1:0] hash_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               hash_ff <= key[AW-1:0];
            end
         end

         assign done = done_ff;
         assign hash = hash_ff;
      end else begin : g_reduce
         localparam int KEY_PAD = ((KEY_W + HASH_STEP - 1) / HASH_STEP) * HASH_STEP;
         localparam int HCNT    = KEY_PAD / HASH_STEP;
         localparam int CNT_W   = $clog2(HCNT + 1);

         logic               busy_ff;
         logic               done_ff;
         logic [CNT_W-1:0]   cnt_ff;
         logic [KEY_PAD-1:0] key_ff;
         logic [AW-1:0]      rem_ff;
         logic [AW-1:0]      rem_in;
         logic [AW-1:0]      r;
         logic [AW:0]        t;

         // HASH_STEP bits of restoring remainder per cycle, MSB first
         always_comb begin
            r = rem_ff;
            t = '0;
            for (int j = 0; j < HASH_STEP; j++) begin
               t = {r, key_ff[KEY_PAD-1-j]};
               if (t >= (AW+1)'(DICT_ENTRIES)) begin
                  t = t - (AW+1)'(DICT_ENTRIES);
               end
               r = t[AW-1:0];
            end
            rem_in = r;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               done_ff <= 1'b0;
               if (start) begin
                  busy_ff <= 1'b1;
                  cnt_ff  <= CNT_W'(HCNT);
               end else if (busy_ff) begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               key_ff <= KEY_PAD'(key);
               rem_ff <= '0;
            end else if (busy_ff) begin
               key_ff <= key_ff << HASH_STEP;
               rem_ff <= rem_in;
            end
         end

         assign done = done_ff;
         assign hash = rem_ff;
      end
   endgenerate

endmodule

// ===== rtl/lzw_dict.sv =====
// Hashed dictionary: one synchronous memory, linear probe lookup, insert on miss
// and a clearing pass. Depends on lzw_pkg and lzw_hash.
module lzw_dict #(
   parameter int DICT_ENTRIES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lzw_pkg::dict_req_type             req,
   input  logic [$clog2(DICT_ENTRIES)-1:0]   req_prefix,
   input  logic [7:0]                        req_byte,
   input  logic [$clog2(DICT_ENTRIES)-1:0]   req_code,
   output lzw_pkg::dict_sts_type             sts,
   output logic [$clog2(DICT_ENTRIES)-1:0]   sts_code
);
   import lzw_pkg::*;

   localparam int AW     = $clog2(DICT_ENTRIES);
   localparam int KEY_W  = AW + HASH_SHIFT;
   // Entry layout: {valid, prefix, byte, code}
   localparam int WORD_W = 1 + AW + BYTE_W + AW;

   dict_state_type    state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     prefix_ff, prefix_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              ins_en_ff, ins_en_in;
   logic [AW-1:0]     ins_code_ff, ins_code_in;

   logic [WORD_W-1:0] mem [DICT_ENTRIES];
   logic [WORD_W-1:0] rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic              we;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;

   logic              hash_start;
   logic [KEY_W-1:0]  hash_key;
   logic              hash_done;
   logic [AW-1:0]     hash_val;

   logic              rd_valid;
   logic [AW-1:0]     rd_prefix;
   logic [BYTE_W-1:0] rd_byte;
   logic [AW-1:0]     rd_code;
   logic              is_literal;
   logic              slot_used;
   logic              slot_match;
   logic [AW-1:0]     idx_next;

   assign {rd_valid, rd_prefix, rd_byte, rd_code} = rd_data_ff;
   assign sts_code = rd_code;

   assign hash_key = {req_prefix, HASH_SHIFT'(0)} ^ KEY_W'(req_byte);

   lzw_hash #(
      .DICT_ENTRIES(DICT_ENTRIES)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .start(hash_start),
      .key  (hash_key),
      .done (hash_done),
      .hash (hash_val)
   );

   // Slot checks on the word read for idx_ff; literal slots count as used
   assign is_literal = idx_ff < AW'(LIT_COUNT);
   assign slot_used  = is_literal || rd_valid;
   assign slot_match = !is_literal && rd_valid && (rd_prefix == prefix_ff)
                       && (rd_byte == byte_ff);
   assign idx_next   = (idx_ff == AW'(DICT_ENTRIES - 1)) ? '0 : idx_ff + AW'(1);

   // Dictionary memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DICT_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      prefix_ff   <= prefix_in;
      byte_ff     <= byte_in;
      ins_en_ff   <= ins_en_in;
      ins_code_ff <= ins_code_in;
   end

   // Probe sequencer: one slot compared per cycle, next read issued alongside
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      prefix_in   = prefix_ff;
      byte_in     = byte_ff;
      ins_en_in   = ins_en_ff;
      ins_code_in = ins_code_ff;
      rd_addr     = idx_ff;
      we          = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = '0;
      hash_start  = 1'b0;
      sts         = '0;

      case (state_ff)
         DICT_CLEAR: begin
            we      = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DICT_ENTRIES - 1)) begin
               state_in = DICT_IDLE;
            end
         end
         DICT_IDLE: begin
            sts.ready = 1'b1;
            if (req.clear) begin
               clr_in   = '0;
               state_in = DICT_CLEAR;
            end else if (req.lookup) begin
               prefix_in   = req_prefix;
               byte_in     = req_byte;
               ins_en_in   = req.insert_en;
               ins_code_in = req_code;
               hash_start  = 1'b1;
               state_in    = DICT_HASH;
            end
         end
         DICT_HASH: begin
            if (hash_done) begin
               rd_addr  = hash_val;
               idx_in   = hash_val;
               cnt_in   = '0;
               state_in = DICT_PROBE;
            end
         end
         DICT_PROBE: begin
            if (!slot_used) begin
               // Free slot ends the probe; the new pair goes here when insertion is enabled
               sts.done = 1'b1;
               we       = ins_en_ff;
               wr_data  = {1'b1, prefix_ff, byte_ff, ins_code_ff};
               state_in = DICT_IDLE;
            end else if (slot_match) begin
               sts.done = 1'b1;
               sts.hit  = 1'b1;
               state_in = DICT_IDLE;
            end else if (cnt_ff == AW'(DICT_ENTRIES - 1)) begin
               // Every slot visited: miss with nowhere to insert
               sts.done = 1'b1;
               state_in = DICT_IDLE;
            end else begin
               idx_in  = idx_next;
               rd_addr = idx_next;
               cnt_in  = cnt_ff + AW'(1);
            end
         end
         default: begin
            state_in = DICT_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

endmodule

// ===== rtl/lzw_pack.sv =====
// Bit packer: codes MSB first into bytes, end-of-stream padding, byte count and
// the output register of the response channel. Depends on lzw_pkg.
module lzw_pack #(
   parameter int DICT_ENTRIES = 4096
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  lzw_pkg::pack_cmd_type                       cmd,
   input  logic [$clog2(DICT_ENTRIES)-1:0]             cmd_code,
   input  logic [$clog2($clog2(DICT_ENTRIES)+1)-1:0]   cmd_width,
   output logic                                        cmd_ready,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [7:0]                                  rsp_out_byte,
   output logic                                        rsp_final_byte,
   output logic [lzw_pkg::COUNT_W-1:0]                 rsp_byte_count
);
   import lzw_pkg::*;

   localparam int AW    = $clog2(DICT_ENTRIES);
   // Room for seven pending bits plus the widest code, in whole bytes
   localparam int ACC_W = ((AW + 14) / 8) * 8;
   localparam int SH_W  = $clog2(ACC_W + 1);
   localparam int TOT_W = $clog2(AW + 8);
   localparam int DRN_W = $clog2(ACC_W / 8 + 1);

   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [2:0]         pc_ff, pc_in;
   logic [DRN_W-1:0]   drain_ff, drain_in;
   logic               last_ff, last_in;
   logic [2:0]         emit_cnt_ff, emit_cnt_in;
   logic [COUNT_W-1:0] bytes_out_ff, bytes_out_in;
   logic [COUNT_W-1:0] final_count_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_out_byte_ff;
   logic               rsp_final_byte_ff;
   logic [COUNT_W-1:0] rsp_byte_count_ff;

   logic [AW-1:0]      code_m;
   logic [TOT_W-1:0]   tot;
   logic [SH_W-1:0]    sh;
   logic [ACC_W-1:0]   placed;
   logic [DRN_W-1:0]   nb;
   logic [COUNT_W:0]   sum;
   logic [COUNT_W-1:0] sat;
   logic               load;
   logic               drop;
   logic               out_free;
   logic               go;
   logic               is_final;

   // Code placed just below the pending bits, left aligned in the accumulator
   assign code_m = cmd_code & ~({AW{1'b1}} << cmd_width);
   assign tot    = TOT_W'(pc_ff) + TOT_W'(cmd_width);
   assign sh     = SH_W'(ACC_W) - SH_W'(tot);
   assign placed = ACC_W'(code_m) << sh;
   // Full bytes, plus a padded byte when the stream ends mid-byte
   assign nb     = DRN_W'(tot >> 3) + DRN_W'(cmd.last && (tot[2:0] != 3'd0));
   assign sum    = (COUNT_W+1)'(bytes_out_ff) + (COUNT_W+1)'(nb);
   assign sat    = (sum > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];

   assign cmd_ready = drain_ff == '0;
   assign load      = cmd.valid && cmd_ready;

   // Bytes past the per-request limit are counted but not delivered
   assign drop     = emit_cnt_ff == 3'(MAX_RESULTS);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go       = (drain_ff != '0) && (drop || out_free);
   assign is_final = last_ff && ((drain_ff == DRN_W'(1))
                     || (emit_cnt_ff == 3'(MAX_RESULTS - 1)));

   always_comb begin
      acc_in       = acc_ff;
      pc_in        = pc_ff;
      drain_in     = drain_ff;
      last_in      = last_ff;
      emit_cnt_in  = emit_cnt_ff;
      bytes_out_in = bytes_out_ff;
      if (load) begin
         acc_in   = acc_ff | placed;
         pc_in    = cmd.last ? 3'd0 : tot[2:0];
         drain_in = nb;
         last_in  = cmd.last;
         if (cmd.first) begin
            emit_cnt_in = '0;
         end
         bytes_out_in = cmd.last ? '0 : sat;
      end else if (go) begin
         acc_in   = acc_ff << 8;
         drain_in = drain_ff - DRN_W'(1);
         if (!drop) begin
            emit_cnt_in = emit_cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pc_ff        <= '0;
         drain_ff     <= '0;
         last_ff      <= 1'b0;
         emit_cnt_ff  <= '0;
         bytes_out_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         drain_ff     <= drain_in;
         last_ff      <= last_in;
         emit_cnt_ff  <= emit_cnt_in;
         bytes_out_ff <= bytes_out_in;
         if (go && !drop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register payload and the stream total
   always_ff @(posedge clock) begin
      if (load && cmd.last) begin
         final_count_ff <= sat;
      end
      if (go && !drop) begin
         rsp_out_byte_ff   <= acc_ff[ACC_W-1 -: 8];
         rsp_final_byte_ff <= is_final;
         rsp_byte_count_ff <= is_final ? final_count_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_final_byte = rsp_final_byte_ff;
   assign rsp_byte_count = rsp_byte_count_ff;

endmodule

// ===== rtl/lzw_hashed_dictionary_compressor.sv =====
// Top level of the streaming LZW compressor: request sequencer, code width and
// next-code tracking. Depends on lzw_pkg, lzw_dict and lzw_pack.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+--------------------
//   req     | req_valid, req_stall, req_data_byte,    | input byte
//           | req_end_of_stream                       |
//   rsp     | rsp_valid, rsp_stall, rsp_out_byte,     | packed output byte
//           | rsp_final_byte, rsp_byte_count          |
//
// The first byte of a stream is only held as the prefix. Any other byte is hashed and then probed
// slot by slot through the single memory read port; a miss also passes through the emit state. A hash
// reducer for a size that is not a power of two works through the key HASH_STEP bits at a time.
// A miss or end of stream also waits for the packer, which drains one byte a cycle while its output
// register is not held. After reset and after each end-of-stream byte a clearing pass over all
// DICT_ENTRIES slots runs with req_stall high. rsp_stall holds the output register; requests
// continue to be taken until the packer itself has to wait on it.
module lzw_hashed_dictionary_compressor #(
   parameter int DICT_ENTRIES = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_end_of_stream,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_final_byte,
   output logic [lzw_pkg::COUNT_W-1:0]  rsp_byte_count
);
   import lzw_pkg::*;

   localparam int AW    = $clog2(DICT_ENTRIES);
   localparam int NC_W  = AW + 1;
   localparam int WID_W = $clog2(AW + 1);

   ctl_state_type     state_ff, state_in;
   logic [AW-1:0]     prefix_ff, prefix_in;
   logic              held_ff, held_in;
   logic              first_ff, first_in;
   logic [NC_W-1:0]   next_code_ff, next_code_in;
   logic [WID_W-1:0]  width_ff, width_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              eos_ff, eos_in;

   dict_req_type      dreq;
   dict_sts_type      dsts;
   logic [AW-1:0]     dict_code;
   pack_cmd_type      pcmd;
   logic              pack_ready;
   logic              accept;
   logic              can_add;

   assign req_stall = !((state_ff == CTL_IDLE) && dsts.ready);
   assign accept    = req_valid && !req_stall;
   assign can_add   = next_code_ff < NC_W'(DICT_ENTRIES);

   lzw_dict #(
      .DICT_ENTRIES(DICT_ENTRIES)
   ) u_dict (
      .clock     (clock),
      .reset     (reset),
      .req       (dreq),
      .req_prefix(prefix_ff),
      .req_byte  (req_data_byte),
      .req_code  (next_code_ff[AW-1:0]),
      .sts       (dsts),
      .sts_code  (dict_code)
   );

   lzw_pack #(
      .DICT_ENTRIES(DICT_ENTRIES)
   ) u_pack (
      .clock         (clock),
      .reset         (reset),
      .cmd           (pcmd),
      .cmd_code      (prefix_ff),
      .cmd_width     (width_ff),
      .cmd_ready     (pack_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_final_byte(rsp_final_byte),
      .rsp_byte_count(rsp_byte_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         prefix_ff    <= '0;
         held_ff      <= 1'b0;
         first_ff     <= 1'b1;
         next_code_ff <= NC_W'(LIT_COUNT);
         width_ff     <= WID_W'(CODE_W_INIT);
      end else begin
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         held_ff      <= held_in;
         first_ff     <= first_in;
         next_code_ff <= next_code_in;
         width_ff     <= width_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      eos_ff  <= eos_in;
   end

   // Request sequencing: lookup, miss emission and end-of-stream flush
   always_comb begin
      state_in       = state_ff;
      prefix_in      = prefix_ff;
      held_in        = held_ff;
      first_in       = first_ff;
      next_code_in   = next_code_ff;
      width_in       = width_ff;
      byte_in        = byte_ff;
      eos_in         = eos_ff;
      dreq           = '0;
      dreq.insert_en = can_add;
      pcmd           = '0;

      case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               byte_in = req_data_byte;
               eos_in  = req_end_of_stream;
               if (!held_ff) begin
                  // Opening byte of a stream only becomes the prefix
                  prefix_in = AW'(req_data_byte);
                  held_in   = 1'b1;
                  first_in  = 1'b1;
                  state_in  = req_end_of_stream ? CTL_EMIT_EOS : CTL_IDLE;
               end else begin
                  dreq.lookup = 1'b1;
                  state_in    = CTL_LOOK;
               end
            end
         end
         CTL_LOOK: begin
            if (dsts.done) begin
               if (dsts.hit) begin
                  prefix_in = dict_code;
                  first_in  = 1'b1;
                  state_in  = eos_ff ? CTL_EMIT_EOS : CTL_IDLE;
               end else begin
                  state_in = CTL_EMIT_MISS;
               end
            end
         end
         CTL_EMIT_MISS: begin
            pcmd.valid = 1'b1;
            pcmd.first = 1'b1;
            if (pack_ready) begin
               prefix_in = AW'(byte_ff);
               // Width grows just before an add once the count hits a power of two
               if (can_add) begin
                  if (next_code_ff >= (NC_W'(1) << width_ff)) begin
                     width_in = width_ff + WID_W'(1);
                  end
                  next_code_in = next_code_ff + NC_W'(1);
               end
               first_in = 1'b0;
               state_in = eos_ff ? CTL_EMIT_EOS : CTL_IDLE;
            end
         end
         CTL_EMIT_EOS: begin
            pcmd.valid = 1'b1;
            pcmd.first = first_ff;
            pcmd.last  = 1'b1;
            if (pack_ready) begin
               held_in      = 1'b0;
               prefix_in    = '0;
               first_in     = 1'b1;
               next_code_in = NC_W'(LIT_COUNT);
               width_in     = WID_W'(CODE_W_INIT);
               dreq.clear   = 1'b1;
               state_in     = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule
